>>> rtl/gef_pkg.sv
// ----------------------------------------------------------------------------
// gef_pkg: shared types and constants for the quad grid topology unit
// Field widths, action codes, register indexes and pipeline payload records.
// ----------------------------------------------------------------------------
package gef_pkg;

	// field and internal widths
	localparam int NODE_W    = 11;           // node count register width
	localparam int COORD_W   = 10;           // col / row / face index width
	localparam int EDGE_W    = 21;           // edge number width
	localparam int H_W       = 2 * NODE_W;   // products of two node counts
	localparam int TOT_W     = H_W + 1;      // total edge count
	localparam int EXT_W     = EDGE_W + 1;   // divider compare width
	localparam int CFG_IDX_W = 1;
	localparam int VAL_W     = 2;
	localparam int SLOTS     = 4;            // results per item, at most
	localparam int SLOT_W    = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NODES_ACROSS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NODES_DOWN   = 1'b1;

	localparam logic [NODE_W-1:0] NODES_MIN = 11'd2;

	// valence codes
	localparam logic [VAL_W-1:0] VAL_NONE = 2'd0;
	localparam logic [VAL_W-1:0] VAL_ONE  = 2'd1;
	localparam logic [VAL_W-1:0] VAL_TWO  = 2'd2;

	typedef enum logic [1:0] {
		ACT_EDGE_NODES   = 2'd0,
		ACT_FACE_EDGES   = 2'd1,
		ACT_FACE_NEIGH   = 2'd2,
		ACT_EDGE_VALENCE = 2'd3
	} action_t;

	// grid geometry, derived from the two node counts
	typedef struct packed {
		logic [NODE_W-1:0] ni;
		logic [NODE_W-1:0] nj;
		logic [NODE_W-1:0] fi;
		logic [NODE_W-1:0] fj;
		logic [H_W-1:0]    h;
		logic [TOT_W-1:0]  total;
	} cfg_t;

	typedef struct packed {
		action_t            action;
		logic [EDGE_W-1:0]  e;
		logic [COORD_W-1:0] c;
		logic [COORD_W-1:0] r;
	} item_t;

	typedef struct packed {
		item_t          item;
		logic           horiz;
		logic           bad_face;
		logic [H_W-1:0] pr;     // r * fi
		logic [H_W-1:0] pc;     // c * fj
	} prod_t;

	// sideband that rides along the divider
	typedef struct packed {
		action_t                       action;
		logic                          horiz;
		logic                          ok;
		logic                          bad_face;
		logic [COORD_W-1:0]            c;
		logic [COORD_W-1:0]            r;
		logic [SLOTS-1:0][EDGE_W-1:0]  edges;
	} side_t;

	typedef struct packed {
		side_t             side;
		logic [EDGE_W-1:0] rem;
		logic [NODE_W-1:0] dsr;
		logic [NODE_W-1:0] quo;
	} div_t;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [EDGE_W-1:0]  edge_out;
		logic               found;
		logic [VAL_W-1:0]   valence;
	} res_t;

endpackage

>>> rtl/gef_cfg.sv
// ----------------------------------------------------------------------------
// gef_cfg: node count registers and derived grid geometry
// Saturates writes into the legal range and keeps face and edge counts.
// ----------------------------------------------------------------------------
module gef_cfg #(
	parameter int CLAMP_HI = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [gef_pkg::CFG_IDX_W-1:0]   index,
	input  logic [gef_pkg::NODE_W-1:0]      wdata,
	output gef_pkg::cfg_t                   cfg
);
	import gef_pkg::*;

	localparam logic [NODE_W-1:0] LIM = NODE_W'(CLAMP_HI);

	logic [NODE_W-1:0] ni_q, nj_q, fi_q, fj_q;
	logic [NODE_W-1:0] wclamp;
	logic [H_W-1:0]    h_q, v_q;
	logic [TOT_W-1:0]  total_q;

	// saturate the written count
	always_comb begin
		wclamp = wdata;
		if (wdata > LIM)       wclamp = LIM;
		if (wdata < NODES_MIN) wclamp = NODES_MIN;
	end

	// node counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ni_q <= NODES_MIN;
			nj_q <= NODES_MIN;
		end else if (wr_en) begin
			if (index == REG_NODES_ACROSS) ni_q <= wclamp;
			else                           nj_q <= wclamp;
		end
	end

	// derived counts: faces and edge counts registered from the node counts, total from the edge counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fi_q    <= NODE_W'(1);
			fj_q    <= NODE_W'(1);
			h_q     <= H_W'(2);
			v_q     <= H_W'(2);
			total_q <= TOT_W'(4);
		end else begin
			fi_q    <= ni_q - NODE_W'(1);
			fj_q    <= nj_q - NODE_W'(1);
			h_q     <= H_W'(ni_q - NODE_W'(1)) * H_W'(nj_q);
			v_q     <= H_W'(ni_q) * H_W'(nj_q - NODE_W'(1));
			total_q <= TOT_W'(h_q) + TOT_W'(v_q);
		end
	end

	assign cfg.ni    = ni_q;
	assign cfg.nj    = nj_q;
	assign cfg.fi    = fi_q;
	assign cfg.fj    = fj_q;
	assign cfg.h     = h_q;
	assign cfg.total = total_q;

endmodule

>>> rtl/gef_front.sv
// ----------------------------------------------------------------------------
// gef_front: input register, face products and divider setup
// Three pipeline stages ahead of the divider.
// ----------------------------------------------------------------------------
module gef_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [1:0]                    action,
	input  logic [gef_pkg::EDGE_W-1:0]    edge_number,
	input  logic [gef_pkg::COORD_W-1:0]   face_col,
	input  logic [gef_pkg::COORD_W-1:0]   face_row,
	input  gef_pkg::cfg_t                 cfg,
	output gef_pkg::div_t                 out,
	output logic                          out_valid
);
	import gef_pkg::*;

	item_t item_s1;
	prod_t prod_s2;
	div_t  div_s3;
	logic  v_s1, v_s2, v_s3;
	div_t  div_d;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: input transfer
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1.action <= action_t'(action);
			item_s1.e      <= edge_number;
			item_s1.c      <= face_col;
			item_s1.r      <= face_row;
		end
	end

	// stage 2: face products, edge class, face range check
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2.item     <= item_s1;
			prod_s2.pr       <= H_W'(item_s1.r) * H_W'(cfg.fi);
			prod_s2.pc       <= H_W'(item_s1.c) * H_W'(cfg.fj);
			prod_s2.horiz    <= H_W'(item_s1.e) < cfg.h;
			prod_s2.bad_face <= (NODE_W'(item_s1.c) >= cfg.fi) ||
			                    (NODE_W'(item_s1.r) >= cfg.fj);
		end
	end

	// stage 3: face edge numbers, edge range check, dividend and divisor
	always_comb begin
		div_d.side.action   = prod_s2.item.action;
		div_d.side.horiz    = prod_s2.horiz;
		div_d.side.bad_face = prod_s2.bad_face;
		div_d.side.c        = prod_s2.item.c;
		div_d.side.r        = prod_s2.item.r;
		div_d.side.ok       = TOT_W'(prod_s2.item.e) < cfg.total;
		div_d.side.edges[0] = EDGE_W'(prod_s2.pr + H_W'(prod_s2.item.c));
		div_d.side.edges[1] = EDGE_W'(prod_s2.pr + H_W'(cfg.fi) + H_W'(prod_s2.item.c));
		div_d.side.edges[2] = EDGE_W'(prod_s2.pc + H_W'(prod_s2.item.r) + cfg.h);
		div_d.side.edges[3] = EDGE_W'(prod_s2.pc + H_W'(cfg.fj) + H_W'(prod_s2.item.r)
		                              + cfg.h);
		div_d.rem = prod_s2.horiz ? prod_s2.item.e
		                          : EDGE_W'(H_W'(prod_s2.item.e) - cfg.h);
		div_d.dsr = prod_s2.horiz ? cfg.fi : cfg.fj;
		div_d.quo = '0;
	end

	always_ff @(posedge clk) begin
		if (en) div_s3 <= div_d;
	end

	assign out       = div_s3;
	assign out_valid = v_s3;

endmodule

>>> rtl/gef_div.sv
// ----------------------------------------------------------------------------
// gef_div: pipelined restoring divider
// One quotient bit per stage, QW stages; the sideband travels alongside.
// ----------------------------------------------------------------------------
module gef_div #(
	parameter int QW = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  gef_pkg::div_t  in,
	input  logic           in_valid,
	output gef_pkg::div_t  out,
	output logic           out_valid
);
	import gef_pkg::*;

	div_t stage_s   [QW];
	logic stage_v_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int BIT = QW - 1 - k;
		div_t src, nxt;
		logic src_v;
		logic [EXT_W-1:0] sh, trial;

		if (k == 0) begin : g_first
			assign src   = in;
			assign src_v = in_valid;
		end else begin : g_next
			assign src   = stage_s[k-1];
			assign src_v = stage_v_s[k-1];
		end

		// trial subtract of the shifted divisor
		always_comb begin
			sh    = EXT_W'(src.dsr) << BIT;
			trial = EXT_W'(src.rem);
			nxt   = src;
			if (trial >= sh) begin
				nxt.rem      = EDGE_W'(trial - sh);
				nxt.quo[BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)  stage_v_s[k] <= 1'b0;
			else if (en)  stage_v_s[k] <= src_v;
		end

		always_ff @(posedge clk) begin
			if (en) stage_s[k] <= nxt;
		end
	end

	assign out       = stage_s[QW-1];
	assign out_valid = stage_v_s[QW-1];

	// an in-range edge leaves a remainder below the divisor
	a_rem_below_dsr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out.side.ok) |-> (out.rem < EDGE_W'(out.dsr)))
		else $error("divider remainder not below divisor");

endmodule

>>> rtl/gef_back.sv
// ----------------------------------------------------------------------------
// gef_back: result builder and output register
// Forms up to four results per item and sends them one per transfer.
// ----------------------------------------------------------------------------
module gef_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gef_pkg::div_t                 in,
	input  logic                          in_valid,
	input  gef_pkg::cfg_t                 cfg,
	output logic                          take,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [gef_pkg::COORD_W-1:0]   col,
	output logic [gef_pkg::COORD_W-1:0]   row,
	output logic [gef_pkg::EDGE_W-1:0]    edge_out,
	output logic                          found,
	output logic [gef_pkg::VAL_W-1:0]     valence,
	output logic                          last
);
	import gef_pkg::*;

	res_t [SLOTS-1:0]  slot_q, slot_d;
	logic [SLOT_W-1:0] nlast_q, nlast_d, idx_q;
	logic              hold_v_q;
	logic              xfer;
	logic [NODE_W-1:0] ec, er, ce, re;
	logic              edge_end;
	res_t              cur;

	// edge coordinates from quotient and remainder
	assign ec = in.side.horiz ? NODE_W'(in.rem) : in.quo;
	assign er = in.side.horiz ? in.quo : NODE_W'(in.rem);
	assign ce = NODE_W'(in.side.c);
	assign re = NODE_W'(in.side.r);
	assign edge_end = in.side.horiz ? (er == '0 || er == cfg.nj - NODE_W'(1))
	                                : (ec == '0 || ec == cfg.ni - NODE_W'(1));

	// build the result slots of one item
	always_comb begin
		slot_d  = '0;
		nlast_d = SLOT_W'(SLOTS - 1);
		unique case (in.side.action)
			ACT_EDGE_NODES: begin
				nlast_d = SLOT_W'(1);
				if (in.side.ok) begin
					slot_d[0].col   = COORD_W'(ec);
					slot_d[0].row   = COORD_W'(er);
					slot_d[0].found = 1'b1;
					slot_d[1].col   = COORD_W'(in.side.horiz ? ec + NODE_W'(1) : ec);
					slot_d[1].row   = COORD_W'(in.side.horiz ? er : er + NODE_W'(1));
					slot_d[1].found = 1'b1;
				end
			end
			ACT_EDGE_VALENCE: begin
				nlast_d         = '0;
				slot_d[0].found = in.side.ok;
				if (in.side.ok) slot_d[0].valence = edge_end ? VAL_ONE : VAL_TWO;
				else            slot_d[0].valence = VAL_NONE;
			end
			ACT_FACE_EDGES: begin
				if (!in.side.bad_face) begin
					for (int k = 0; k < SLOTS; k++) begin
						slot_d[k].edge_out = in.side.edges[k];
						slot_d[k].found    = 1'b1;
					end
				end
			end
			ACT_FACE_NEIGH: begin
				if (!in.side.bad_face) begin
					// below, above, left, right
					if (re != '0) begin
						slot_d[0].col   = in.side.c;
						slot_d[0].row   = COORD_W'(re - NODE_W'(1));
						slot_d[0].found = 1'b1;
					end
					if (re + NODE_W'(1) < cfg.fj) begin
						slot_d[1].col   = in.side.c;
						slot_d[1].row   = COORD_W'(re + NODE_W'(1));
						slot_d[1].found = 1'b1;
					end
					if (ce != '0) begin
						slot_d[2].col   = COORD_W'(ce - NODE_W'(1));
						slot_d[2].row   = in.side.r;
						slot_d[2].found = 1'b1;
					end
					if (ce + NODE_W'(1) < cfg.fi) begin
						slot_d[3].col   = COORD_W'(ce + NODE_W'(1));
						slot_d[3].row   = in.side.r;
						slot_d[3].found = 1'b1;
					end
				end
			end
		endcase
	end

	// output register takes a new item once the last result has moved
	assign xfer = hold_v_q && !rsp_stall;
	assign take = !hold_v_q || (xfer && idx_q == nlast_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			idx_q    <= '0;
		end else if (take) begin
			hold_v_q <= in_valid;
			idx_q    <= '0;
		end else if (xfer) begin
			idx_q    <= idx_q + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			slot_q  <= slot_d;
			nlast_q <= nlast_d;
		end
	end

	assign cur       = slot_q[idx_q];
	assign rsp_valid = hold_v_q;
	assign col       = cur.col;
	assign row       = cur.row;
	assign edge_out  = cur.edge_out;
	assign found     = cur.found;
	assign valence   = cur.valence;
	assign last      = idx_q == nlast_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> (idx_q <= nlast_q))
		else $error("result index past last slot");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && !last) |=> (hold_v_q && idx_q == $past(idx_q) + SLOT_W'(1)))
		else $error("result sequence broken");

endmodule

>>> rtl/grid_edge_face_topology_top.sv
// ----------------------------------------------------------------------------
// grid_edge_face_topology_top: structured quad grid topology unit
// Edge end nodes, face edges, face neighbours and edge valence on a grid
// whose node counts per axis are set through the configuration port.
// ----------------------------------------------------------------------------
// Usage:
//   Queries come in on the req channel (req_valid / req_stall) and results
//   leave on the rsp channel (rsp_valid / rsp_stall); last marks the final
//   result of a query. Edge end nodes give two results, face edges and face
//   neighbours four, edge valence one.
//   Node counts are written with cfg_wr_en / cfg_index / cfg_wdata while the
//   block is idle; the derived counts are registered from them.
//   Path: a query passes the input, product and setup registers, then the QW
//   stages of the pipelined divider, one quotient bit each, and then the
//   output register that holds its results.
//   Throughput: a query enters every cycle while req_stall is low; the rsp
//   channel moves one result per cycle while rsp_stall is low.
//   Reset: both node counts return to 2 and the pipeline empties.
//   Stall: while the output register cannot take a new item and the divider
//   has a valid item at its end, the pipeline freezes and req_stall rises.
// ----------------------------------------------------------------------------
module grid_edge_face_topology_top #(
	parameter int MAX_NODES_PER_AXIS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [gef_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gef_pkg::NODE_W-1:0]      cfg_wdata,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [1:0]                      action,
	input  logic [gef_pkg::EDGE_W-1:0]      edge_number,
	input  logic [gef_pkg::COORD_W-1:0]     face_col,
	input  logic [gef_pkg::COORD_W-1:0]     face_row,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [gef_pkg::COORD_W-1:0]     col,
	output logic [gef_pkg::COORD_W-1:0]     row,
	output logic [gef_pkg::EDGE_W-1:0]      edge_out,
	output logic                            found,
	output logic [gef_pkg::VAL_W-1:0]       valence,
	output logic                            last
);
	import gef_pkg::*;

	// counts saturate at the parameter and at the register width
	localparam int CLAMP_HI = (MAX_NODES_PER_AXIS > 2047) ? 2047 : MAX_NODES_PER_AXIS;
	localparam int QW       = $clog2(CLAMP_HI);

	cfg_t cfg;
	div_t front_out, div_out;
	logic front_v, div_v;
	logic take, en;

	// whole pipeline moves unless its last stage is blocked
	assign en        = !div_v || take;
	assign req_stall = !en;

	gef_cfg #(.CLAMP_HI(CLAMP_HI)) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	gef_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (req_valid),
		.action      (action),
		.edge_number (edge_number),
		.face_col    (face_col),
		.face_row    (face_row),
		.cfg         (cfg),
		.out         (front_out),
		.out_valid   (front_v)
	);

	gef_div #(.QW(QW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in        (front_out),
		.in_valid  (front_v),
		.out       (div_out),
		.out_valid (div_v)
	);

	gef_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (div_out),
		.in_valid  (div_v),
		.cfg       (cfg),
		.take      (take),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.col       (col),
		.row       (row),
		.edge_out  (edge_out),
		.found     (found),
		.valence   (valence),
		.last      (last)
	);

endmodule
